FILE: hdl/sgtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgtp_pkg
// Shared widths, register indexes and reason codes of the stream policer.
// ----------------------------------------------------------------------------
package sgtp_pkg;

  localparam int unsigned LenW    = 16;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned PerW    = 32;
  localparam int unsigned RateW   = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 64;
  localparam int unsigned ProdW   = TimeW + RateW;
  localparam logic [31:0] NsPerSec = 32'd1000000000;

  typedef enum logic [CfgIdxW-1:0] {
    RegFilterOn = 3'd0,
    RegGateOn   = 3'd1,
    RegPeriod   = 3'd2,
    RegOpen     = 3'd3,
    RegClose    = 3'd4,
    RegRate     = 3'd5,
    RegBurst    = 3'd6,
    RegSpare    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ReasonPass    = 2'd0,
    ReasonOff     = 2'd1,
    ReasonGate    = 2'd2,
    ReasonTokens  = 2'd3
  } reason_e;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic [TimeW-1:0] arrival_time_ns;
  } req_t;

  typedef struct packed {
    logic           accept;
    logic [1:0]     drop_reason;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_t;

endpackage

FILE: hdl/sgtp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgtp_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface sgtp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/sgtp_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgtp_serdiv
// Restoring divider, one quotient bit per cycle, remainder kept narrow.
// ----------------------------------------------------------------------------
module sgtp_serdiv #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  assign shifted = {rem_q, num_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

FILE: hdl/stream_gate_and_token_policer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_gate_and_token_policer_core
// Per-stream filter with time window gate and token bucket policer.
// ----------------------------------------------------------------------------
// One frame at a time. A frame dropped by a disabled filter goes straight to
// the output state; any other frame is gated, if the gate is on, and then
// policed. With the gate on, open, close and phase are each reduced mod the
// period by the bit-serial divider over its 104-bit numerator. A refill adds
// a shift-add multiply of rate by elapsed time and a serial divide by 1e9.
// The result sits in an output register; the next frame is accepted once
// that result has been taken, or in the cycle it is taken.
module stream_gate_and_token_policer_core (
  input  logic clk_i,
  input  logic rst_ni,
  sgtp_stream_if.sink   req,
  sgtp_stream_if.source rsp,
  sgtp_stream_if.sink   cfg
);
  import sgtp_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StModOpen, StModClose, StModPhase, StGateChk,
    StPolice, StMul, StDiv, StDecide, StOut
  } state_e;

  state_e            state_q;
  logic              filter_on_q, gate_on_q;
  logic [PerW-1:0]   period_q, open_q, close_q, o_q, c_q;
  logic [RateW-1:0]  rate_q, burst_q, tokens_q;
  logic [TimeW-1:0]  last_q;
  logic [LenW-1:0]   len_q;
  logic [TimeW-1:0]  t_q;
  logic              out_valid_q;
  rsp_t              out_q;
  // multiplier: shift-add over elapsed time bits
  logic [ProdW-1:0]  prod_q;
  logic [TimeW-1:0]  mplier_q;
  logic [6:0]        mcnt_q;

  logic              div_start;
  logic [ProdW-1:0]  div_num;
  logic [31:0]       div_den;
  logic              div_done;
  logic [ProdW-1:0]  div_quo;
  logic [31:0]       div_rem;
  logic [RateW-1:0]  cap;
  logic [TimeW-1:0]  elapsed;

  assign cap     = (burst_q == '0) ? rate_q : burst_q;
  assign elapsed = t_q - last_q;

  sgtp_serdiv #(.NumW(ProdW), .DenW(32)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  assign req.ready = (state_q == StIdle) && !(out_valid_q && !rsp.ready);
  assign cfg.ready = (state_q == StIdle);
  assign rsp.valid   = out_valid_q;
  assign rsp.payload = out_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = NsPerSec;
    case (state_q)
      StIdle: begin
        div_num = ProdW'(open_q);
        div_den = period_q;
        div_start = req.valid && req.ready && filter_on_q && gate_on_q
                    && (period_q != '0);
      end
      StModOpen: begin
        div_num = ProdW'(close_q); div_den = period_q; div_start = div_done;
      end
      StModClose: begin
        div_num = ProdW'(t_q); div_den = period_q; div_start = div_done;
      end
      StMul: begin
        div_num = prod_q; div_start = (mcnt_q == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      filter_on_q <= 1'b0;
      gate_on_q   <= 1'b0;
      period_q    <= '0;
      open_q      <= '0;
      close_q     <= '0;
      rate_q      <= '0;
      burst_q     <= '0;
      tokens_q    <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
      out_q       <= '0;
      len_q       <= '0;
      t_q         <= '0;
      o_q         <= '0;
      c_q         <= '0;
      prod_q      <= '0;
      mplier_q    <= '0;
    end else begin
      if ((state_q == StOut) && (!out_valid_q || rsp.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.payload.index))
          RegFilterOn: filter_on_q <= cfg.payload.data[0];
          RegGateOn:   gate_on_q   <= cfg.payload.data[0];
          RegPeriod:   period_q    <= cfg.payload.data[PerW-1:0];
          RegOpen:     open_q      <= cfg.payload.data[PerW-1:0];
          RegClose:    close_q     <= cfg.payload.data[PerW-1:0];
          RegRate:     rate_q      <= cfg.payload.data[RateW-1:0];
          RegBurst:    burst_q     <= cfg.payload.data[RateW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (req.valid && req.ready) begin
            len_q <= req.payload.frame_length;
            t_q   <= req.payload.arrival_time_ns;
            if (!filter_on_q) begin
              out_q.drop_reason <= ReasonOff;
              state_q <= StOut;
            end else if (gate_on_q && (period_q != '0)) begin
              state_q <= StModOpen;
            end else begin
              state_q <= StPolice;
            end
          end
        end
        StModOpen:  if (div_done) begin o_q <= div_rem; state_q <= StModClose; end
        StModClose: if (div_done) begin c_q <= div_rem; state_q <= StModPhase; end
        StModPhase: if (div_done) state_q <= StGateChk;
        StGateChk: begin
          if ((o_q < c_q) && (div_rem >= o_q) && (div_rem < c_q)) begin
            state_q <= StPolice;
          end else begin
            out_q.drop_reason <= ReasonGate;
            state_q <= StOut;
          end
        end
        StPolice: begin
          if (rate_q == '0) begin
            out_q.drop_reason <= ReasonPass;
            state_q <= StOut;
          end else if (last_q == '0) begin
            // first policed frame: start clock, clamp bucket
            last_q <= t_q;
            if (tokens_q > cap) tokens_q <= cap;
            state_q <= StDecide;
          end else if (t_q > last_q) begin
            prod_q   <= '0;
            mplier_q <= elapsed;
            mcnt_q   <= 7'd64;
            state_q  <= StMul;
          end else begin
            last_q  <= t_q;
            state_q <= StDecide;
          end
        end
        StMul: begin
          if (mcnt_q != '0) begin
            prod_q <= {prod_q[ProdW-2:0], 1'b0}
                      + (mplier_q[TimeW-1] ? ProdW'(rate_q) : '0);
            mplier_q <= {mplier_q[TimeW-2:0], 1'b0};
            mcnt_q <= mcnt_q - 1'b1;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            // full 104-bit quotient is compared; anything past cap fills bucket
            if ((div_quo >= ProdW'(cap)) || (tokens_q >= cap)
                || (div_quo >= ProdW'(cap - tokens_q)))
              tokens_q <= cap;
            else
              tokens_q <= tokens_q + div_quo[RateW-1:0];
            last_q  <= t_q;
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (tokens_q >= RateW'(len_q)) begin
            tokens_q <= tokens_q - RateW'(len_q);
            out_q.drop_reason <= ReasonPass;
          end else begin
            out_q.drop_reason <= ReasonTokens;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (!out_valid_q || rsp.ready) begin
            out_q.accept <= (out_q.drop_reason == ReasonPass);
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: hdl/sgtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgtp_checker
// Port-level checks of the policer, bound to the top level.
// ----------------------------------------------------------------------------
module sgtp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_accept,
  input logic [1:0] rsp_reason,
  input logic cfg_ready
);
  import sgtp_pkg::*;

  a_accept_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_accept == (rsp_reason == ReasonPass)))
    else $error("accept flag disagrees with reason");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reason))
    else $error("stalled result changed");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !cfg_ready)
    else $error("config open while request in flight");
endmodule

bind stream_gate_and_token_policer_core sgtp_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_accept(rsp.payload.accept), .rsp_reason(rsp.payload.drop_reason),
  .cfg_ready(cfg.ready)
);
